// File: rtl/btl_pkg.sv
// ----------------------------------------------------------------------------
// btl_pkg
// Shared types and codes for the boot timestamp log table.
// ----------------------------------------------------------------------------
package btl_pkg;

  // request action codes
  localparam logic [2:0] ACT_ADD         = 3'd0;
  localparam logic [2:0] ACT_SINCE_BOOT  = 3'd1;
  localparam logic [2:0] ACT_SINCE_RESET = 3'd2;
  localparam logic [2:0] ACT_STAMP       = 3'd3;
  localparam logic [2:0] ACT_RESET_STAMP = 3'd4;
  localparam logic [2:0] ACT_MIX         = 3'd5;

  // register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_TABLE_PRESENT = 3'd0;
  localparam logic [2:0] REG_RAW_MODE      = 3'd1;
  localparam logic [2:0] REG_BASE_TIME     = 3'd2;
  localparam logic [2:0] REG_CAPACITY      = 3'd3;
  localparam logic [2:0] REG_TICKS_PER_US  = 3'd4;

  // one queued request, classified by the front end
  typedef struct packed {
    logic        known;
    logic [2:0]  action;
    logic [31:0] event_id;
    logic [63:0] time_now;
    logic [5:0]  entry_index;
    logic [7:0]  data_byte;
  } item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic        table_present;
    logic        raw_mode;
    logic [63:0] tick_offset;
    logic [6:0]  capacity_limit;
    logic [15:0] ticks_per_us;
  } cfg_t;

endpackage

// File: rtl/boot_timestamp_log_table.sv
// ----------------------------------------------------------------------------
// boot_timestamp_log_table
// Boot timestamp log: appends id and stamp pairs and answers time queries.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Requests wait in
//   a two-deep queue; busy is high while that queue is full.
//   Each request gives one result on result_value and success, shown for
//   one cycle with done high; the receiver cannot stall it.
//   Adds and unknown actions are answered from the dispatch state, mix after
//   a table read. Time queries use a 64-step divider; raw pre-reset queries
//   add a set-up step and those where microseconds are first scaled add a
//   multiply. Id queries add a search of the table and a set-up step; the
//   first pre-reset query adds a minimum scan of the table.
//   Requests run one at a time, in order.
//   Registers sit on the APB port at byte address 8 * index; pready is
//   always high and writes are meant only while the block is idle.
//   Reset (rst, synchronous) empties the queue and the table, clears the
//   latched earliest stamp and restores the register defaults.
// ----------------------------------------------------------------------------
module boot_timestamp_log_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  action,
  input  logic [31:0] event_id,
  input  logic [63:0] time_now,
  input  logic [5:0]  entry_index,
  input  logic [7:0]  data_byte,
  output logic        busy,
  output logic        done,
  output logic [63:0] result_value,
  output logic        success,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import btl_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_present  <= 1'b1;
      cfg.raw_mode       <= 1'b1;
      cfg.tick_offset    <= '0;
      cfg.capacity_limit <= 7'd64;
      cfg.ticks_per_us   <= 16'd1;
    end else if (wr_en) begin
      unique case (paddr[5:3])
        REG_TABLE_PRESENT: cfg.table_present  <= pwdata[0];
        REG_RAW_MODE:      cfg.raw_mode       <= pwdata[0];
        REG_BASE_TIME:     cfg.tick_offset    <= pwdata;
        REG_CAPACITY:      cfg.capacity_limit <= pwdata[6:0];
        REG_TICKS_PER_US:  cfg.ticks_per_us   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[5:3])
      REG_TABLE_PRESENT: prdata = 64'(cfg.table_present);
      REG_RAW_MODE:      prdata = 64'(cfg.raw_mode);
      REG_BASE_TIME:     prdata = cfg.tick_offset;
      REG_CAPACITY:      prdata = 64'(cfg.capacity_limit);
      REG_TICKS_PER_US:  prdata = 64'(cfg.ticks_per_us);
      default:           prdata = '0;
    endcase
  end

  btl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .event_id    (event_id),
    .time_now    (time_now),
    .entry_index (entry_index),
    .data_byte   (data_byte),
    .busy        (busy),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  btl_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .done         (done),
    .result_value (result_value),
    .success      (success)
  );

endmodule

// File: rtl/btl_front.sv
// ----------------------------------------------------------------------------
// btl_front
// Accepts requests, classifies the action and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module btl_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2:0]     action,
  input  logic [31:0]    event_id,
  input  logic [63:0]    time_now,
  input  logic [5:0]     entry_index,
  input  logic [7:0]     data_byte,
  output logic           busy,
  output logic           q_valid,
  output btl_pkg::item_t q_item,
  input  logic           q_pop
);
  import btl_pkg::*;

  item_t      slot [2];
  logic [1:0] fill;
  logic       wp;
  logic       rp;
  logic       push;
  item_t      item_in;

  // classify: actions past the mix code are unknown
  always_comb begin
    item_in.known       = (action <= ACT_MIX);
    item_in.action      = action;
    item_in.event_id    = event_id;
    item_in.time_now    = time_now;
    item_in.entry_index = entry_index;
    item_in.data_byte   = data_byte;
  end

  assign busy    = (fill == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_item  = slot[rp];

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
      wp   <= 1'b0;
      rp   <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop && q_valid) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wp] <= item_in;
  end

endmodule

// File: rtl/btl_div.sv
// ----------------------------------------------------------------------------
// btl_div
// 64 by 16 bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module btl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  localparam int W  = 64;
  localparam int NW = $clog2(W);

  logic          run;
  logic [NW-1:0] cnt;
  logic [15:0]   rem;
  logic [W-1:0]  q;
  logic [16:0]   sh;
  logic          fits;

  // one trial subtraction
  assign sh       = {rem, q[W-1]};
  assign fits     = (sh >= {1'b0, divisor});
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        q   <= dividend;
      end else if (run) begin
        rem <= fits ? 16'(sh - {1'b0, divisor}) : sh[15:0];
        q   <= {q[W-2:0], fits};
        cnt <= cnt + NW'(1);
        if (cnt == NW'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/btl_back.sv
// ----------------------------------------------------------------------------
// btl_back
// Carries out queued requests: table writes, id search, minimum scan and
// the division that scales stamps to microseconds.
// ----------------------------------------------------------------------------
module btl_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  btl_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  btl_pkg::item_t q_item,
  output logic           q_pop,
  output logic           done,
  output logic [63:0]    result_value,
  output logic           success
);
  import btl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SRCH   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_MULSUM = 4'd5;
  localparam logic [3:0] S_PREP   = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_MIX    = 4'd9;

  localparam logic [1:0] POST_NONE = 2'd0;
  localparam logic [1:0] POST_NEG  = 2'd1;
  localparam logic [1:0] POST_SUB  = 2'd2;

  logic [3:0]    state;
  item_t         cur;
  logic [CW-1:0] count;
  logic          latched;
  logic [63:0]   earl;
  logic [CW-1:0] ptr;
  logic          pend;
  logic [63:0]   stamp;
  logic [47:0]   prod_lo;
  logic [47:0]   prod_hi;
  logic [63:0]   cur_t;
  logic [63:0]   divd;
  logic          neg;
  logic [1:0]    post;
  logic          okr;

  logic [31:0]   id_mem [TABLE_DEPTH];
  logic [63:0]   st_mem [TABLE_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [31:0]   id_rd;
  logic [63:0]   st_rd;
  logic          mem_we;

  logic [15:0]   f;
  logic          add_ok;
  logic          mix_ok;
  logic          issue;
  logic [63:0]   sv;
  logic          div_start;
  logic          div_done;
  logic [63:0]   quo;

  // tick rate, zero taken as one
  assign f = (cfg.ticks_per_us == 16'd0) ? 16'd1 : cfg.ticks_per_us;

  assign add_ok = cfg.table_present && (32'(count) < 32'(cfg.capacity_limit))
                  && (count < DEPTH_C);
  assign mix_ok = cfg.table_present && (32'(cur.entry_index) < 32'(count));
  assign issue  = (ptr < count);

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign mem_we    = (state == S_DISP) && (cur.action == ACT_ADD) && add_ok;
  assign div_start = (state == S_DSTART);
  assign rd_addr   = (state == S_SRCH || state == S_SCAN) ? ptr[AW-1:0]
                                                          : AW'(cur.entry_index);

  // stamp for the id queries, less the earliest for the pre-reset form
  assign sv = (cur.action == ACT_RESET_STAMP) ? stamp - earl : stamp;

  // table memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[count[AW-1:0]] <= cur.event_id;
      st_mem[count[AW-1:0]] <= cur.time_now - cfg.tick_offset;
    end
    id_rd <= id_mem[rd_addr];
    st_rd <= st_mem[rd_addr];
  end

  btl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (divd),
    .divisor  (f),
    .done     (div_done),
    .quotient (quo)
  );

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      latched <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_DISP;
          end
        end

        S_DISP: begin
          okr   <= 1'b0;
          post  <= POST_NONE;
          cur_t <= cur.time_now;
          ptr   <= '0;
          pend  <= 1'b0;
          if (!cur.known) begin
            result_value <= '0;
            success      <= 1'b0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            unique case (cur.action)
              ACT_ADD: begin
                if (add_ok) count <= count + CW'(1);
                result_value <= '0;
                success      <= add_ok;
                done         <= 1'b1;
                state        <= S_IDLE;
              end
              ACT_SINCE_BOOT, ACT_SINCE_RESET: begin
                if (!cfg.table_present) begin
                  if (cfg.raw_mode) begin
                    divd  <= cur.time_now;
                    state <= S_DSTART;
                  end else begin
                    result_value <= cur.time_now;
                    success      <= 1'b0;
                    done         <= 1'b1;
                    state        <= S_IDLE;
                  end
                end else if (cur.action == ACT_SINCE_BOOT) begin
                  okr <= 1'b1;
                  if (cfg.raw_mode) begin
                    divd <= cur.time_now - cfg.tick_offset;
                  end else begin
                    divd <= cfg.tick_offset;
                    post <= POST_SUB;
                  end
                  state <= S_DSTART;
                end else begin
                  okr <= 1'b1;
                  if (!latched) begin
                    earl  <= '0;
                    state <= S_SCAN;
                  end else begin
                    state <= cfg.raw_mode ? S_PREP : S_MUL;
                  end
                end
              end
              ACT_STAMP, ACT_RESET_STAMP: begin
                if (!cfg.table_present) begin
                  result_value <= '0;
                  success      <= 1'b0;
                  done         <= 1'b1;
                  state        <= S_IDLE;
                end else begin
                  stamp <= '0;
                  state <= S_SRCH;
                end
              end
              ACT_MIX: begin
                if (mix_ok) begin
                  state <= S_MIX;
                end else begin
                  result_value <= 64'(cur.data_byte);
                  success      <= 1'b0;
                  done         <= 1'b1;
                  state        <= S_IDLE;
                end
              end
              default: begin
                result_value <= '0;
                success      <= 1'b0;
                done         <= 1'b1;
                state        <= S_IDLE;
              end
            endcase
          end
        end

        // first matching id, one read a cycle
        S_SRCH: begin
          pend <= issue;
          if (issue) ptr <= ptr + CW'(1);
          if (pend && id_rd == cur.event_id) begin
            okr   <= 1'b1;
            stamp <= st_rd;
          end
          if ((pend && id_rd == cur.event_id) || (!issue && !pend)) begin
            ptr  <= '0;
            pend <= 1'b0;
            if (cur.action == ACT_RESET_STAMP && !latched) begin
              earl  <= '0;
              state <= S_SCAN;
            end else begin
              state <= S_PREP;
            end
          end
        end

        // signed minimum over the table, starting from zero
        S_SCAN: begin
          pend <= issue;
          if (issue) ptr <= ptr + CW'(1);
          if (pend && ($signed(st_rd) < $signed(earl))) earl <= st_rd;
          if (!issue && !pend) begin
            latched <= 1'b1;
            if (cur.action == ACT_SINCE_RESET && !cfg.raw_mode) state <= S_MUL;
            else state <= S_PREP;
          end
        end

        // time in microseconds scaled to ticks, in two halves
        S_MUL: begin
          prod_lo <= cur.time_now[31:0] * f;
          prod_hi <= cur.time_now[63:32] * f;
          state   <= S_MULSUM;
        end

        S_MULSUM: begin
          cur_t <= 64'(prod_lo) + {prod_hi[31:0], 32'd0};
          state <= S_PREP;
        end

        S_PREP: begin
          if (cur.action == ACT_SINCE_RESET) begin
            divd <= cur_t - cfg.tick_offset - earl;
            post <= POST_NONE;
          end else begin
            neg  <= sv[63];
            divd <= sv[63] ? 64'd0 - sv : sv;
            post <= POST_NEG;
          end
          state <= S_DSTART;
        end

        S_DSTART: begin
          state <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            unique case (post)
              POST_NEG: result_value <= neg ? 64'd0 - quo : quo;
              POST_SUB: result_value <= cur.time_now - quo;
              default:  result_value <= quo;
            endcase
            success <= okr;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end

        S_MIX: begin
          result_value <= 64'(cur.data_byte ^ st_rd[7:0]);
          success      <= 1'b1;
          done         <= 1'b1;
          state        <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/btl_checker.sv
// ----------------------------------------------------------------------------
// btl_checker
// Port-level checks on the boot timestamp log table, bound to the top level.
// ----------------------------------------------------------------------------
module btl_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done
);

  // no result straight out of reset
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // queue is empty after reset
  a_ready_after_rst: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

  // result strobes never come back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobes in consecutive cycles");

endmodule

bind boot_timestamp_log_table btl_checker u_btl_checker (
  .clk  (clk),
  .rst  (rst),
  .busy (busy),
  .done (done)
);
